// File: rtl/olie_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olie_pkg
// shared types and constants of the ordered list insert/erase engine
// ----------------------------------------------------------------------------
package olie_pkg;

    localparam int FUNC_W  = 3;
    localparam int POS_W   = 9;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 9;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_POP_BACK   = 3'd1,
        FN_PUSH_FRONT = 3'd2,
        FN_POP_FRONT  = 3'd3,
        FN_INSERT     = 3'd4,
        FN_ERASE      = 3'd5,
        FN_CLEAR      = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     err;
    } olie_ctl_t;

endpackage
`default_nettype wire

// File: rtl/ordered_list_insert_erase_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_engine_top
// the result appears on done in the cycle after the start beat
// throughput: one command per cycle, busy stays low
// the entries that move shift in the same cycle through a row of DEPTH cells
// reset clears the internal entry count and the result strobe; entry contents are not reset
// the receiver cannot stall, each result is shown for one cycle
// ----------------------------------------------------------------------------
module ordered_list_insert_erase_engine_top #(
    parameter int DEPTH = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [olie_pkg::FUNC_W-1:0]   func,
    input  wire logic [olie_pkg::POS_W-1:0]    position,
    input  wire logic [olie_pkg::DATA_W-1:0]   value_in,
    output logic                               done,
    output logic      [olie_pkg::DATA_W-1:0]   value_out,
    output logic      [olie_pkg::COUNT_W-1:0]  count,
    output logic                               error
);
    import olie_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    olie_ctl_t         ctl;
    logic [CW-1:0]     ep;
    logic [CW-1:0]     held;
    logic [CW-1:0]     held_nxt;
    logic [DATA_W-1:0] q_w   [DEPTH];
    logic [DATA_W-1:0] sel_w [DEPTH];
    logic [DATA_W-1:0] picked;

    logic               done_reg;
    logic [DATA_W-1:0]  value_out_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               error_reg;

    olie_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .func     (func),
        .position (position),
        .ctl      (ctl),
        .ep       (ep),
        .held     (held),
        .held_nxt (held_nxt)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid
            assign left_w = q_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_inner
            assign right_w = q_w[i+1];
        end

        olie_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .ep       (ep),
            .left     (left_w),
            .right    (right_w),
            .value_in (value_in),
            .q        (q_w[i]),
            .sel      (sel_w[i])
        );
    end

    always_comb
    begin
        picked = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            picked = picked | sel_w[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            value_out_reg <= (ctl.op == OP_REMOVE) ? picked : '0;
            count_reg     <= COUNT_W'(held_nxt);
            error_reg     <= ctl.err;
        end
    end

    assign busy      = 1'b0;
    assign done      = done_reg;
    assign value_out = value_out_reg;
    assign count     = count_reg;
    assign error     = error_reg;

`ifndef SYNTHESIS
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("missing result beat after start");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> !done)
        else $error("result beat without command");

    a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        held <= CW'(DEPTH))
        else $error("count beyond depth");

    a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error) |-> (value_out == '0))
        else $error("refused command returned a value");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (start && func == FN_CLEAR) |=> (held == '0 && !error))
        else $error("clear left entries");
`endif

endmodule
`default_nettype wire

// File: rtl/olie_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olie_cell
// one list entry; shifts toward the back on insert, toward the front on removal
// ----------------------------------------------------------------------------
module olie_cell #(
    parameter int IDX = 0,
    parameter int CW  = 9
) (
    input  wire logic                       clk,
    input  wire olie_pkg::olie_ctl_t        ctl,
    input  wire logic [CW-1:0]              ep,
    input  wire logic [olie_pkg::DATA_W-1:0] left,
    input  wire logic [olie_pkg::DATA_W-1:0] right,
    input  wire logic [olie_pkg::DATA_W-1:0] value_in,
    output logic      [olie_pkg::DATA_W-1:0] q,
    output logic      [olie_pkg::DATA_W-1:0] sel
);
    import olie_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (IDX_C > ep)
                begin
                    data_next = left;
                end
                else if (IDX_C == ep)
                begin
                    data_next = value_in;
                end
            end
            OP_REMOVE:
            begin
                if (IDX_C >= ep)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q   = data_reg;
    assign sel = (IDX_C == ep) ? data_reg : '0;

endmodule
`default_nettype wire

// File: rtl/olie_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olie_ctrl
// command decode, range checks and entry count
// ----------------------------------------------------------------------------
module olie_ctrl #(
    parameter int DEPTH = 256,
    parameter int CW    = 9
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [olie_pkg::FUNC_W-1:0]  func,
    input  wire logic [olie_pkg::POS_W-1:0]   position,
    output olie_pkg::olie_ctl_t               ctl,
    output logic      [CW-1:0]                ep,
    output logic      [CW-1:0]                held,
    output logic      [CW-1:0]                held_nxt
);
    import olie_pkg::*;

    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [CW-1:0]   held_reg;
    logic [CW-1:0]   held_next;
    logic [CMPW-1:0] held_x;
    logic [CMPW-1:0] pos_x;
    logic            full;
    logic            empty;
    olie_ctl_t       dec;
    logic [CW-1:0]   dec_ep;

    assign held_x = CMPW'(held_reg);
    assign pos_x  = CMPW'(position);
    assign full   = (held_reg == DEPTH_C);
    assign empty  = (held_reg == '0);

    always_comb
    begin
        dec.op  = OP_NONE;
        dec.err = 1'b0;
        dec_ep  = '0;
        unique case (func)
            FN_PUSH_BACK:
            begin
                dec_ep = held_reg;
                if (full) dec.err = 1'b1;
                else      dec.op  = OP_INSERT;
            end
            FN_POP_BACK:
            begin
                dec_ep = held_reg - CW'(1);
                if (empty) dec.err = 1'b1;
                else       dec.op  = OP_REMOVE;
            end
            FN_PUSH_FRONT:
            begin
                if (full) dec.err = 1'b1;
                else      dec.op  = OP_INSERT;
            end
            FN_POP_FRONT:
            begin
                if (empty) dec.err = 1'b1;
                else       dec.op  = OP_REMOVE;
            end
            FN_INSERT:
            begin
                dec_ep = CW'(pos_x);
                if (full || (pos_x > held_x)) dec.err = 1'b1;
                else                          dec.op  = OP_INSERT;
            end
            FN_ERASE:
            begin
                dec_ep = CW'(pos_x);
                if (pos_x >= held_x) dec.err = 1'b1;
                else                 dec.op  = OP_REMOVE;
            end
            FN_CLEAR:
            begin
                dec.op = OP_CLEAR;
            end
            default:
            begin
                dec.err = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        ctl = dec;
        if (!start)
        begin
            ctl.op = OP_NONE;
        end
    end

    always_comb
    begin
        held_next = held_reg;
        case (ctl.op)
            OP_INSERT: held_next = held_reg + CW'(1);
            OP_REMOVE: held_next = held_reg - CW'(1);
            OP_CLEAR:  held_next = '0;
            default:   held_next = held_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    assign ep       = dec_ep;
    assign held     = held_reg;
    assign held_nxt = held_next;

endmodule
`default_nettype wire

// File: verif/ordered_list_insert_erase_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_engine_top_tb
// drives push, pop, insert, erase and clear commands into the list engine and
// checks every result beat against a behavioral copy of the list, covering
// empty and full lists, out-of-range positions and the unused command code,
// with random idle gaps on the command side
// ----------------------------------------------------------------------------
module ordered_list_insert_erase_engine_top_tb;

    import olie_pkg::*;

    localparam int LIST_DEPTH = 256;
    localparam logic [FUNC_W-1:0] FN_UNDEFINED = 3'd7;
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIXED  = 2;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct {
        logic [DATA_W-1:0]  value;
        logic [COUNT_W-1:0] count;
        logic               err;
    } list_result_t;

    class list_checker;
        logic [DATA_W-1:0] entries [LIST_DEPTH];
        int held;
        int peak_held;
        int n_commands;
        int n_checked;
        int n_refused;
        int errors;
        list_result_t pending_results [$];

        function new();
            held = 0;
            peak_held = 0;
            n_commands = 0;
            n_checked = 0;
            n_refused = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        function void open_slot(int pos, logic [DATA_W-1:0] v);
            for (int i = held; i > pos; i--)
                entries[i] = entries[i-1];
            entries[pos] = v;
            held++;
            if (held > peak_held)
                peak_held = held;
        endfunction

        function logic [DATA_W-1:0] close_slot(int pos);
            logic [DATA_W-1:0] v;
            v = entries[pos];
            for (int i = pos; i + 1 < held; i++)
                entries[i] = entries[i+1];
            held--;
            return v;
        endfunction

        function void note_command(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos,
                                   logic [DATA_W-1:0] v);
            list_result_t r;
            r.value = '0;
            r.err = 1'b0;
            case (fn)
                FN_PUSH_BACK:
                    if (held >= LIST_DEPTH) r.err = 1'b1;
                    else open_slot(held, v);
                FN_POP_BACK:
                    if (held == 0) r.err = 1'b1;
                    else r.value = close_slot(held - 1);
                FN_PUSH_FRONT:
                    if (held >= LIST_DEPTH) r.err = 1'b1;
                    else open_slot(0, v);
                FN_POP_FRONT:
                    if (held == 0) r.err = 1'b1;
                    else r.value = close_slot(0);
                FN_INSERT:
                    if (held >= LIST_DEPTH || int'(pos) > held) r.err = 1'b1;
                    else open_slot(int'(pos), v);
                FN_ERASE:
                    if (int'(pos) >= held) r.err = 1'b1;
                    else r.value = close_slot(int'(pos));
                FN_CLEAR:
                    held = 0;
                default:
                    r.err = 1'b1;
            endcase
            r.count = COUNT_W'(held);
            n_commands++;
            pending_results = {pending_results, r};
        endfunction

        task check_result(logic [DATA_W-1:0] v, logic [COUNT_W-1:0] c, logic e);
            list_result_t r;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result beat with nothing pending: value %0h count %0d",
                                 v, c));
                return;
            end
            r = pending_results.pop_front();
            n_checked++;
            if (r.err)
                n_refused++;
            if (v !== r.value)
                report($sformatf("value_out %0h, expected %0h", v, r.value));
            if (c !== r.count)
                report($sformatf("count %0d, expected %0d", c, r.count));
            if (e !== r.err)
                report($sformatf("error %b, expected %b", e, r.err));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [FUNC_W-1:0]   func = '0;
    logic [POS_W-1:0]    position = '0;
    logic [DATA_W-1:0]   value_in = '0;
    logic                busy;
    logic                done;
    logic [DATA_W-1:0]   value_out;
    logic [COUNT_W-1:0]  count;
    logic                error;

    list_checker sb;
    bit no_idle = 1'b0;

    ordered_list_insert_erase_engine_top #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .position(position),
        .value_in(value_in),
        .done(done),
        .value_out(value_out),
        .count(count),
        .error(error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(value_out, count, error);
    end

    // leaves start high at the accept edge so the next beat can follow directly
    task send_command(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p, logic [DATA_W-1:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        func     <= f;
        position <= p;
        value_in <= v;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(f, p, v);
    endtask

    function logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task send_random(int mode);
        int roll;
        int ins_pct;
        logic [FUNC_W-1:0] f;
        logic [POS_W-1:0]  p;
        ins_pct = (mode == MODE_GROW) ? 95 : (mode == MODE_SHRINK) ? 15 : 50;
        roll = $urandom_range(0, 99);
        p = POS_W'($urandom_range(0, 511));
        if (roll < 6)
        begin
            f = FUNC_W'($urandom_range(0, 7));
            if (mode == MODE_GROW && f == FN_CLEAR)
                f = FN_PUSH_BACK;
        end
        else if (mode != MODE_GROW && roll < 7)
        begin
            f = FN_CLEAR;
        end
        else if ($urandom_range(0, 99) < ins_pct)
        begin
            case ($urandom_range(0, 2))
                0: f = FN_PUSH_BACK;
                1: f = FN_PUSH_FRONT;
                default:
                begin
                    f = FN_INSERT;
                    p = POS_W'($urandom_range(0, sb.held));
                end
            endcase
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: f = FN_POP_BACK;
                1: f = FN_POP_FRONT;
                default:
                begin
                    f = FN_ERASE;
                    p = POS_W'($urandom_range(0, (sb.held > 0) ? sb.held - 1 : 0));
                end
            endcase
        end
        send_command(f, p, pick_value());
    endtask

    task run_episode(int mode, int len);
        no_idle = ($urandom_range(0, 2) == 0);
        repeat (len) send_random(mode);
    endtask

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results still pending", sb.pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int issued;
        int len;
        int mode;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, range checks, extreme values
        send_command(FN_CLEAR,      9'd0,   32'h0);
        send_command(FN_POP_BACK,   9'd0,   32'h0);
        send_command(FN_POP_FRONT,  9'd0,   32'h0);
        send_command(FN_ERASE,      9'd0,   32'h0);
        send_command(FN_INSERT,     9'd1,   32'h1111_1111);
        send_command(FN_UNDEFINED,  9'd0,   32'hffff_ffff);
        send_command(FN_INSERT,     9'd0,   32'h8000_0000);
        send_command(FN_PUSH_BACK,  9'd0,   32'h7fff_ffff);
        send_command(FN_PUSH_FRONT, 9'd511, 32'hffff_ffff);
        send_command(FN_INSERT,     9'd3,   32'h0);
        send_command(FN_INSERT,     9'd1,   32'h1234_5678);
        send_command(FN_ERASE,      9'd5,   32'h0);
        send_command(FN_ERASE,      9'd511, 32'h0);
        send_command(FN_INSERT,     9'd511, 32'h5555_aaaa);
        send_command(FN_ERASE,      9'd2,   32'h0);
        send_command(FN_POP_BACK,   9'd0,   32'h0);
        send_command(FN_POP_FRONT,  9'd0,   32'h0);
        send_command(FN_ERASE,      9'd0,   32'h0);
        send_command(FN_PUSH_BACK,  9'd0,   32'haaaa_5555);
        send_command(FN_CLEAR,      9'd0,   32'h0);
        send_command(FN_POP_BACK,   9'd0,   32'h0);

        // fill past full, then drain past empty, then mixed episodes
        run_episode(MODE_GROW, 330);
        run_episode(MODE_SHRINK, 300);
        issued = 630;
        while (issued < RANDOM_ITEMS)
        begin
            len = $urandom_range(20, 120);
            mode = $urandom_range(MODE_GROW, MODE_MIXED);
            run_episode(mode, len);
            issued += len;
        end
        start <= 1'b0;

        for (int i = 0; i < 1000 && sb.pending_results.size() > 0; i++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.pending_results.size() > 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));

        $display("%0d commands issued, %0d results checked, %0d refused",
                 sb.n_commands, sb.n_checked, sb.n_refused);
        $display("list fill peaked at %0d of %0d entries", sb.peak_held, LIST_DEPTH);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
